// ===== hw/rtl/cre_pkg.sv =====
// Package for the coverage range encoder: record types and shared constants.
// No dependencies; every other file of the block imports it.
`default_nettype none

package cre_pkg;

  // Field widths.
  localparam int unsigned GidW = 16;
  localparam int unsigned CntW = 17;

  // Saturation value of the 17-bit counters.
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // Default depth of the result queue; two entries at least.
  localparam int unsigned CreOutDepth = 4;

  // One range record as delivered on the result channel.
  typedef struct packed {
    logic [GidW-1:0] range_start;
    logic [GidW-1:0] range_end;
    logic [GidW-1:0] start_index;
    logic            final_res;
    logic [CntW-1:0] range_total;
    logic [CntW-1:0] item_total;
    logic            list_form_shorter;
  } cre_rec_t;

  // Records produced by one item: rec0 first, rec1 only together with rec0.
  typedef struct packed {
    logic     push0;
    logic     push1;
    cre_rec_t rec0;
    cre_rec_t rec1;
  } cre_push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cre_if.sv =====
// Handshake interfaces of the coverage range encoder: id channel and range record channel.
// Depends on cre_pkg for the field widths.
`default_nettype none

interface cre_in_if;
  import cre_pkg::*;

  logic            valid;
  logic            ready;
  logic [GidW-1:0] glyph_id;
  logic            last;

  modport source (output valid, output glyph_id, output last, input ready);
  modport sink   (input valid, input glyph_id, input last, output ready);
endinterface

interface cre_out_if;
  import cre_pkg::*;

  logic            valid;
  logic            ready;
  logic [GidW-1:0] range_start;
  logic [GidW-1:0] range_end;
  logic [GidW-1:0] start_index;
  logic            final_res;
  logic [CntW-1:0] range_total;
  logic [CntW-1:0] item_total;
  logic            list_form_shorter;

  modport source (output valid, output range_start, output range_end, output start_index,
                  output final_res, output range_total, output item_total,
                  output list_form_shorter, input ready);
  modport sink   (input valid, input range_start, input range_end, input start_index,
                  input final_res, input range_total, input item_total,
                  input list_form_shorter, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/coverage_range_encoder.sv =====
// Coverage range encoder: ascending glyph ids in, range records out.
// An accepted id waits in the input register, then its records are queued and offered.
// Throughput: one id per cycle while the queue has room; an id that both breaks a run
// and closes the list yields two records, leaving one per cycle while out_if is ready.
// Reset clears the run state, the counters and the queue at once; no clearing pass.
`default_nettype none

module coverage_range_encoder
  import cre_pkg::*;
#(
  parameter int unsigned OutDepth = CreOutDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cre_in_if.sink     in_if,
  cre_out_if.source  out_if
);

  localparam int unsigned CntWd = $clog2(OutDepth + 1);

  logic             pipe_v_q;
  logic [GidW-1:0]  pipe_gid_q;
  logic             pipe_last_q;
  logic             consume;
  logic             room;
  logic [CntWd-1:0] count;
  cre_push_t        push;
  cre_rec_t         out_rec;

  // Input register: refilled whenever its item moves on.
  assign consume     = pipe_v_q && room;
  assign in_if.ready = !pipe_v_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_v_q <= 1'b0;
    end else if (in_if.ready) begin
      pipe_v_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      pipe_gid_q  <= in_if.glyph_id;
      pipe_last_q <= in_if.last;
    end
  end

  // Run tracking and record forming.
  cre_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (consume),
    .glyph_id_i (pipe_gid_q),
    .last_i     (pipe_last_q),
    .push_o     (push)
  );

  // Result queue.
  cre_out_fifo #(
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .count_o     (count),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_rec_o   (out_rec)
  );

  assign out_if.range_start       = out_rec.range_start;
  assign out_if.range_end         = out_rec.range_end;
  assign out_if.start_index       = out_rec.start_index;
  assign out_if.final_res         = out_rec.final_res;
  assign out_if.range_total       = out_rec.range_total;
  assign out_if.item_total        = out_rec.item_total;
  assign out_if.list_form_shorter = out_rec.list_form_shorter;

  // The queue never overfills.
  a_fifo_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntWd'(OutDepth))
    else $error("result queue overfilled");

  // An accepted id lands in the input register.
  a_pipe_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> pipe_v_q)
    else $error("accepted id lost");

  // A waiting id in the input register holds until the queue has room.
  a_pipe_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_v_q && !consume) |=> (pipe_v_q && $stable(pipe_gid_q) && $stable(pipe_last_q)))
    else $error("stalled id changed");

endmodule

`default_nettype wire

// ===== hw/rtl/cre_core.sv =====
// Run tracking of the coverage range encoder: holds the open run and the list counters,
// and forms up to two range records per id. Depends on cre_pkg.
`default_nettype none

module cre_core
  import cre_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            go_i,
  input  wire logic [GidW-1:0] glyph_id_i,
  input  wire logic            last_i,
  output cre_push_t            push_o
);

  logic [GidW-1:0] run_first_q, run_first_d;
  logic [GidW-1:0] run_last_q, run_last_d;
  logic            have_run_q, have_run_d;
  logic [CntW-1:0] items_q, items_d;
  logic [CntW-1:0] distinct_q, distinct_d;
  logic [CntW-1:0] ranges_q, ranges_d;

  logic [CntW-1:0] items_inc;
  logic [CntW-1:0] ranges_mid;
  logic [CntW-1:0] ranges_fin;
  logic [CntW-1:0] last_plus1;
  logic            is_drop;
  logic            is_ext;
  logic            is_brk;
  logic [CntW+1:0] ranges_x3;
  cre_rec_t        brk_rec;
  cre_rec_t        fin_rec;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? v : v + CntW'(1);
  endfunction

  // Index of a run's first id among the distinct ids kept so far.
  function automatic logic [GidW-1:0] start_idx(input logic [CntW-1:0] kept,
                                                input logic [GidW-1:0] first,
                                                input logic [GidW-1:0] lst);
    start_idx = kept[GidW-1:0] - (lst - first) - GidW'(1);
  endfunction

  // Classify the id against the open run.
  always_comb begin
    last_plus1 = {1'b0, run_last_q} + CntW'(1);
    is_drop    = have_run_q && (glyph_id_i <= run_last_q);
    is_ext     = have_run_q && ({1'b0, glyph_id_i} == last_plus1);
    is_brk     = have_run_q && !is_drop && !is_ext;
    items_inc  = sat_inc(items_q);
    ranges_mid = is_brk ? sat_inc(ranges_q) : ranges_q;
    ranges_fin = sat_inc(ranges_mid);
  end

  // Run state after this id, before a list close.
  always_comb begin
    run_first_d = run_first_q;
    run_last_d  = run_last_q;
    have_run_d  = have_run_q;
    distinct_d  = distinct_q;
    if (!have_run_q) begin
      run_first_d = glyph_id_i;
      run_last_d  = glyph_id_i;
      have_run_d  = 1'b1;
      distinct_d  = CntW'(1);
    end else if (is_ext) begin
      run_last_d = glyph_id_i;
      distinct_d = distinct_q + CntW'(1);
    end else if (is_brk) begin
      run_first_d = glyph_id_i;
      run_last_d  = glyph_id_i;
      distinct_d  = distinct_q + CntW'(1);
    end
    items_d  = items_inc;
    ranges_d = ranges_mid;
  end

  // Record for a broken run and record for the final run.
  always_comb begin
    brk_rec                   = '0;
    brk_rec.range_start       = run_first_q;
    brk_rec.range_end         = run_last_q;
    brk_rec.start_index       = start_idx(distinct_q, run_first_q, run_last_q);

    ranges_x3                 = {2'b00, ranges_fin} + {1'b0, ranges_fin, 1'b0};
    fin_rec.range_start       = run_first_d;
    fin_rec.range_end         = run_last_d;
    fin_rec.start_index       = start_idx(distinct_d, run_first_d, run_last_d);
    fin_rec.final_res         = 1'b1;
    fin_rec.range_total       = ranges_fin;
    fin_rec.item_total        = items_inc;
    fin_rec.list_form_shorter = ({2'b00, items_inc} < ranges_x3);
  end

  // Records handed to the result queue.
  always_comb begin
    push_o.push0 = go_i && (is_brk || last_i);
    push_o.push1 = go_i && is_brk && last_i;
    push_o.rec0  = is_brk ? brk_rec : fin_rec;
    push_o.rec1  = fin_rec;
  end

  // State update; a list close returns everything to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_first_q <= '0;
      run_last_q  <= '0;
      have_run_q  <= 1'b0;
      items_q     <= '0;
      distinct_q  <= '0;
      ranges_q    <= '0;
    end else if (go_i) begin
      if (last_i) begin
        run_first_q <= '0;
        run_last_q  <= '0;
        have_run_q  <= 1'b0;
        items_q     <= '0;
        distinct_q  <= '0;
        ranges_q    <= '0;
      end else begin
        run_first_q <= run_first_d;
        run_last_q  <= run_last_d;
        have_run_q  <= have_run_d;
        items_q     <= items_d;
        distinct_q  <= distinct_d;
        ranges_q    <= ranges_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cre_out_fifo.sv =====
// Result queue of the coverage range encoder: takes up to two records a cycle and
// delivers one per request. Depends on cre_pkg.
`default_nettype none

module cre_out_fifo
  import cre_pkg::*;
#(
  parameter int unsigned Depth = CreOutDepth,
  localparam int unsigned PtrW = $clog2(Depth),
  localparam int unsigned CntWd = $clog2(Depth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  cre_push_t             push_i,
  output logic                  room_o,
  output logic [CntWd-1:0]      count_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output cre_rec_t              out_rec_o
);

  cre_rec_t         mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  wr_ptr1;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntWd-1:0] count_q, count_d;
  logic             pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // Pointer and fill bookkeeping.
  always_comb begin
    pop      = out_valid_o && out_ready_i;
    wr_ptr1  = ptr_inc(wr_ptr_q);
    wr_ptr_d = push_i.push1 ? ptr_inc(wr_ptr1) : (push_i.push0 ? wr_ptr1 : wr_ptr_q);
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntWd'(push_i.push0) + CntWd'(push_i.push1) - CntWd'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Record storage.
  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_ptr_q] <= push_i.rec0;
    end
    if (push_i.push1) begin
      mem_q[wr_ptr1] <= push_i.rec1;
    end
  end

  // Head of the queue and space for two more records.
  assign out_valid_o = (count_q != '0);
  assign out_rec_o   = mem_q[rd_ptr_q];
  assign room_o      = (count_q <= CntWd'(Depth - 2));
  assign count_o     = count_q;

endmodule

`default_nettype wire

// ===== test/coverage_range_encoder_checker.sv =====
// Checker for the coverage range encoder: watches the id and range record channels,
// predicts the range records of each list and compares them field by field.
// Depends on cre_pkg and the channel interfaces in cre_if.sv.

module coverage_range_encoder_checker
  import cre_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cre_in_if           in_if,
  cre_out_if          out_if,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Open run and counters of the list being encoded.
  logic [GidW-1:0] open_first;
  logic [GidW-1:0] open_last;
  logic            run_open;
  logic [CntW-1:0] id_count;
  logic [CntW-1:0] kept_count;
  logic [CntW-1:0] range_count;

  cre_rec_t    expected_ranges[$];
  int unsigned fail_cnt;

  function automatic void clear_list();
    open_first  = '0;
    open_last   = '0;
    run_open    = 1'b0;
    id_count    = '0;
    kept_count  = '0;
    range_count = '0;
  endfunction

  // Builds the record of the open run; totals are only filled in on the final one.
  function automatic cre_rec_t close_range(logic fin);
    cre_rec_t        rec;
    logic [CntW-1:0] span;
    int unsigned     list_bytes;
    int unsigned     range_bytes;
    span        = {1'b0, open_last} - {1'b0, open_first} + 17'd1;
    list_bytes  = 2 * int'(id_count);
    range_bytes = 6 * int'(range_count);
    rec.range_start       = open_first;
    rec.range_end         = open_last;
    rec.start_index       = kept_count[GidW-1:0] - span[GidW-1:0];
    rec.final_res         = fin;
    rec.range_total       = fin ? range_count : '0;
    rec.item_total        = fin ? id_count : '0;
    rec.list_form_shorter = fin && (list_bytes < range_bytes);
    return rec;
  endfunction

  // Advances the encoder state by one id and queues the records it yields.
  function automatic void predict_ranges(logic [GidW-1:0] gid, logic lst);
    if (id_count != CntMax) id_count++;
    if (!run_open) begin
      open_first = gid;
      open_last  = gid;
      run_open   = 1'b1;
      kept_count = CntW'(1);
    end else if (gid > open_last) begin
      // An equal or smaller id never gets here; it is dropped but still counted.
      if ({1'b0, gid} == {1'b0, open_last} + 17'd1) begin
        open_last = gid;
        kept_count++;
      end else begin
        if (range_count != CntMax) range_count++;
        expected_ranges.push_back(close_range(1'b0));
        open_first = gid;
        open_last  = gid;
        kept_count++;
      end
    end
    if (lst) begin
      if (range_count != CntMax) range_count++;
      expected_ranges.push_back(close_range(1'b1));
      clear_list();
    end
  endfunction

  function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Compares an accepted record with the oldest expected one.
  function automatic void check_range_record();
    cre_rec_t got;
    cre_rec_t want;
    got.range_start       = out_if.range_start;
    got.range_end         = out_if.range_end;
    got.start_index       = out_if.start_index;
    got.final_res         = out_if.final_res;
    got.range_total       = out_if.range_total;
    got.item_total        = out_if.item_total;
    got.list_form_shorter = out_if.list_form_shorter;
    if (expected_ranges.size() == 0) begin
      $error("range record %0d..%0d arrived with none expected",
             got.range_start, got.range_end);
      fail_cnt++;
    end else begin
      want = expected_ranges.pop_front();
      fail_cnt += field_diff("range_start", 32'(want.range_start), 32'(got.range_start));
      fail_cnt += field_diff("range_end", 32'(want.range_end), 32'(got.range_end));
      fail_cnt += field_diff("start_index", 32'(want.start_index), 32'(got.start_index));
      fail_cnt += field_diff("final_res", 32'(want.final_res), 32'(got.final_res));
      fail_cnt += field_diff("range_total", 32'(want.range_total), 32'(got.range_total));
      fail_cnt += field_diff("item_total", 32'(want.item_total), 32'(got.item_total));
      fail_cnt += field_diff("list_form_shorter", 32'(want.list_form_shorter),
                             32'(got.list_form_shorter));
    end
  endfunction

  // Records are checked before new ids are predicted; none can leave on the edge
  // that takes its id.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_list();
      expected_ranges.delete();
      fail_cnt = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (out_if.valid && out_if.ready) check_range_record();
      if (in_if.valid && in_if.ready) predict_ranges(in_if.glyph_id, in_if.last);
      fail_cnt_o <= fail_cnt;
      pending_o  <= expected_ranges.size();
    end
  end

endmodule

// ===== test/coverage_range_encoder_tb.sv =====
// Testbench top for the coverage range encoder: clock, reset, id lists and output stalls.
// Depends on cre_pkg, cre_if.sv, the encoder RTL and coverage_range_encoder_checker.

module coverage_range_encoder_tb;
  import cre_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomIds  = 750;
  localparam int unsigned QuietLimit = 2000;

  // Directed lists; bit 16 is the last mark.
  localparam int unsigned DirectedCnt = 21;
  localparam logic [16:0] DirectedIds [DirectedCnt] = '{
    // Single id at each end of the id space.
    {1'b1, 16'd0}, {1'b1, 16'd65535},
    // Duplicate, smaller id, run break, and a break that closes the list.
    {1'b0, 16'd5}, {1'b0, 16'd6}, {1'b0, 16'd7}, {1'b0, 16'd7},
    {1'b0, 16'd6}, {1'b0, 16'd10}, {1'b0, 16'd11}, {1'b1, 16'd20},
    // One run only, so the range form wins.
    {1'b0, 16'd0}, {1'b0, 16'd1}, {1'b0, 16'd2}, {1'b1, 16'd3},
    // Duplicate that carries the last mark.
    {1'b0, 16'd100}, {1'b1, 16'd100},
    // Break at the top, then a dropped smaller id closes the list.
    {1'b0, 16'd65533}, {1'b0, 16'd65535}, {1'b1, 16'd0},
    // Run that ends at the largest id.
    {1'b0, 16'd65534}, {1'b1, 16'd65535}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_idle_on;
  logic        out_stall_on;
  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned quiet_cycles = 0;

  cre_in_if  id_ch ();
  cre_out_if rec_ch ();

  coverage_range_encoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (id_ch),
    .out_if (rec_ch)
  );

  coverage_range_encoder_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (id_ch),
    .out_if     (rec_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt)
  );

  always #5ns clk_i = ~clk_i;

  // Sends one id, maybe after an idle burst, and returns on the edge that takes it.
  task automatic push_id(input logic [GidW-1:0] gid, input logic lst);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      id_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    id_ch.valid    <= 1'b1;
    id_ch.glyph_id <= gid;
    id_ch.last     <= lst;
    @(posedge clk_i);
    while (!id_ch.ready) @(posedge clk_i);
  endtask

  // Holds the id channel until every expected record has been delivered.
  task automatic wait_for_drain();
    id_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  // One list of mostly ascending ids with runs, gaps, duplicates and some noise.
  task automatic send_random_list(inout int unsigned sent);
    int unsigned len;
    int unsigned roll;
    int unsigned nxt;
    logic [GidW-1:0] top_id;
    logic [GidW-1:0] gid;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 24);
    case ($urandom_range(0, 7))
      0:       top_id = 16'(65535 - $urandom_range(0, 12));
      1:       top_id = 16'($urandom_range(0, 12));
      default: top_id = 16'($urandom_range(0, 65535));
    endcase
    for (int unsigned k = 0; k < len; k++) begin
      roll = $urandom_range(0, 99);
      if (k == 0) begin
        gid = top_id;
      end else if (roll < 45) begin
        gid = (top_id == 16'hFFFF) ? top_id : top_id + 16'd1;
      end else if (roll < 75) begin
        nxt = top_id + (($urandom_range(0, 3) == 0) ? $urandom_range(2, 4096)
                                                      : $urandom_range(2, 9));
        gid = (nxt > 65535) ? top_id : nxt[GidW-1:0];
      end else if (roll < 88) begin
        gid = top_id;
      end else begin
        gid = 16'($urandom_range(0, 65535));
      end
      if (gid > top_id) top_id = gid;
      push_id(gid, k == len - 1);
      sent++;
    end
  endtask

  // Output side: random stall bursts while enabled.
  initial begin
    rec_ch.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (out_stall_on && $urandom_range(0, 3) == 0) begin
        rec_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        rec_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((id_ch.valid && id_ch.ready) || (rec_ch.valid && rec_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("[coverage_range_encoder] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned lists;
    int unsigned random_sent;
    lists       = 0;
    random_sent = 0;
    in_idle_on   = 1'b1;
    out_stall_on = 1'b1;
    rst_ni         <= 1'b0;
    id_ch.valid    <= 1'b0;
    id_ch.glyph_id <= '0;
    id_ch.last     <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lists.
    foreach (DirectedIds[i]) push_id(DirectedIds[i][15:0], DirectedIds[i][16]);
    wait_for_drain();

    // Random lists with changing idle patterns; the tail runs at full rate.
    while (random_sent < RandomIds) begin
      if (random_sent > RandomIds - 120) begin
        in_idle_on   = 1'b0;
        out_stall_on = 1'b0;
      end else if (lists % 4 == 0) begin
        in_idle_on   = $urandom_range(0, 2) != 0;
        out_stall_on = $urandom_range(0, 2) != 0;
      end
      send_random_list(random_sent);
      lists++;
      if (lists % 9 == 0 && in_idle_on) wait_for_drain();
    end

    wait_for_drain();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[coverage_range_encoder] OK");
    end else begin
      $display("[coverage_range_encoder] ERROR");
    end
    $finish;
  end

endmodule
